// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define MFMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define MFMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/mfmt_pkg.sv =====
package mfmt_pkg;

  localparam int NumMotors = 4;
  localparam int MotorIdxW = (NumMotors > 1) ? $clog2(NumMotors) : 1;

  localparam logic [10:0] BaseIdReset = 11'd513;

  localparam logic signed [16:0] TurnUp   = 17'sd4096;
  localparam logic signed [16:0] TurnDown = -17'sd4096;

  localparam int AngleShift = 13;

  typedef enum logic [1:0] {
    ActFrame  = 2'd0,
    ActOffset = 2'd1,
    ActZero   = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [10:0] frame_id;
    logic [7:0]  data_byte_0;
    logic [7:0]  data_byte_1;
    logic [7:0]  data_byte_2;
    logic [7:0]  data_byte_3;
    logic [7:0]  data_byte_4;
    logic [7:0]  data_byte_5;
    logic [7:0]  data_byte_6;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         motor_index;
    logic [15:0]        angle;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic [7:0]         hall;
    logic signed [31:0] round_count;
    logic signed [31:0] accum_angle;
    logic signed [31:0] relative_angle;
  } result_t;

endpackage

// ===== rtl/mfmt_if.sv =====
interface mfmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [10:0] frame_id;
  logic [7:0]  data_byte_0;
  logic [7:0]  data_byte_1;
  logic [7:0]  data_byte_2;
  logic [7:0]  data_byte_3;
  logic [7:0]  data_byte_4;
  logic [7:0]  data_byte_5;
  logic [7:0]  data_byte_6;

  modport source (
    output valid, action, frame_id, data_byte_0, data_byte_1, data_byte_2,
           data_byte_3, data_byte_4, data_byte_5, data_byte_6,
    input  ready
  );
  modport sink (
    input  valid, action, frame_id, data_byte_0, data_byte_1, data_byte_2,
           data_byte_3, data_byte_4, data_byte_5, data_byte_6,
    output ready
  );
endinterface

interface mfmt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         motor_index;
  logic [15:0]        angle;
  logic signed [15:0] speed;
  logic signed [15:0] current;
  logic [7:0]         hall;
  logic signed [31:0] round_count;
  logic signed [31:0] accum_angle;
  logic signed [31:0] relative_angle;

  modport source (
    output valid, motor_index, angle, speed, current, hall, round_count,
           accum_angle, relative_angle,
    input  ready
  );
  modport sink (
    input  valid, motor_index, angle, speed, current, hall, round_count,
           accum_angle, relative_angle,
    output ready
  );
endinterface

interface mfmt_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] base_id;

  modport source (output valid, base_id, input ready);
  modport sink (input valid, base_id, output ready);
endinterface

// ===== rtl/motor_feedback_multiturn_tracker_core.sv =====
// Channel   Dir   Handshake      Request content
// cfg_i     in    valid/ready    base_id, identifier of motor 0
// in_i      in    valid/ready    action, frame_id, payload bytes 0 to 6
// out_o     out   valid/ready    motor index, unpacked fields, turn count, angles
//
// One request is accepted per cycle unless a stalled result holds s1_q. A request is
// held in s1_q and its result in out_q; the per-motor state registers set the rate.
// Commands and frames for unknown motors pass through s1_q and give no result. A stalled
// result holds only requests that give a result; reset sets all state but s1_q and out_q.
module motor_feedback_multiturn_tracker_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mfmt_cfg_if.sink   cfg_i,
  mfmt_in_if.sink    in_i,
  mfmt_out_if.source out_o
);
  import mfmt_pkg::*;

  logic [10:0]          base_id_q;
  logic                 s1_valid_q;
  in_item_t             s1_q;
  logic                 out_valid_q;
  result_t              out_q;

  logic [15:0]          angle_q  [NumMotors];
  logic [31:0]          round_q  [NumMotors];
  logic [15:0]          offset_q [NumMotors];
  logic [31:0]          total_q  [NumMotors];
  logic [31:0]          zero_q   [NumMotors];

  logic [11:0]          id_off;
  logic                 hit;
  logic [MotorIdxW-1:0] idx;
  logic [15:0]          ang;
  logic signed [16:0]   ang_diff;
  logic [31:0]          round_d;
  logic [31:0]          total_d;
  logic [31:0]          rel_d;
  logic                 s1_adv;

  assign cfg_i.ready = 1'b1;

  assign id_off   = {1'b0, s1_q.frame_id} - {1'b0, base_id_q};
  assign hit      = (s1_q.action == ActFrame) && !id_off[11] && (id_off < 12'(NumMotors));
  assign idx      = id_off[MotorIdxW-1:0];
  assign ang      = {s1_q.data_byte_0, s1_q.data_byte_1};
  assign ang_diff = $signed({1'b0, ang}) - $signed({1'b0, angle_q[idx]});

  always_comb begin
    if (ang_diff > TurnUp) begin
      round_d = round_q[idx] - 32'd1;
    end else if (ang_diff < TurnDown) begin
      round_d = round_q[idx] + 32'd1;
    end else begin
      round_d = round_q[idx];
    end
  end

  assign total_d = {round_d[31-AngleShift:0], {AngleShift{1'b0}}}
                 + {16'd0, ang} - {16'd0, offset_q[idx]};
  assign rel_d   = total_d - zero_q[idx];

  assign s1_adv     = s1_valid_q && (!hit || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_id_q <= BaseIdReset;
    end else if (cfg_i.valid) begin
      base_id_q <= cfg_i.base_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q.action      <= in_i.action;
      s1_q.frame_id    <= in_i.frame_id;
      s1_q.data_byte_0 <= in_i.data_byte_0;
      s1_q.data_byte_1 <= in_i.data_byte_1;
      s1_q.data_byte_2 <= in_i.data_byte_2;
      s1_q.data_byte_3 <= in_i.data_byte_3;
      s1_q.data_byte_4 <= in_i.data_byte_4;
      s1_q.data_byte_5 <= in_i.data_byte_5;
      s1_q.data_byte_6 <= in_i.data_byte_6;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < NumMotors; m++) begin
        angle_q[m]  <= '0;
        round_q[m]  <= '0;
        offset_q[m] <= '0;
        total_q[m]  <= '0;
        zero_q[m]   <= '0;
      end
    end else if (s1_adv) begin
      case (action_e'(s1_q.action))
        ActFrame: begin
          if (hit) begin
            angle_q[idx] <= ang;
            round_q[idx] <= round_d;
            total_q[idx] <= total_d;
          end
        end
        ActOffset: begin
          for (int m = 0; m < NumMotors; m++) begin
            offset_q[m] <= angle_q[m];
          end
        end
        ActZero: begin
          for (int m = 0; m < NumMotors; m++) begin
            zero_q[m] <= total_q[m];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && hit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && hit) begin
      out_q.motor_index    <= 2'(idx);
      out_q.angle          <= ang;
      out_q.speed          <= $signed({s1_q.data_byte_2, s1_q.data_byte_3});
      out_q.current        <= $signed({s1_q.data_byte_4, s1_q.data_byte_5});
      out_q.hall           <= s1_q.data_byte_6;
      out_q.round_count    <= $signed(round_d);
      out_q.accum_angle    <= $signed(total_d);
      out_q.relative_angle <= $signed(rel_d);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.motor_index    = out_q.motor_index;
  assign out_o.angle          = out_q.angle;
  assign out_o.speed          = out_q.speed;
  assign out_o.current        = out_q.current;
  assign out_o.hall           = out_q.hall;
  assign out_o.round_count    = out_q.round_count;
  assign out_o.accum_angle    = out_q.accum_angle;
  assign out_o.relative_angle = out_q.relative_angle;

endmodule

// ===== rtl/mfmt_checker.sv =====
`include "assert_macros.svh"

module mfmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_motor_index_i,
  input logic [31:0] out_round_count_i,
  input logic [31:0] out_accum_angle_i,
  input logic [31:0] out_relative_angle_i
);
  import mfmt_pkg::*;

  `MFMT_ASSERT(a_out_valid_holds, out_valid_i && !out_ready_i |=> out_valid_i,
    "result dropped while stalled")
  `MFMT_ASSERT(a_out_payload_holds, out_valid_i && !out_ready_i |=>
    $stable(out_motor_index_i) && $stable(out_round_count_i) &&
    $stable(out_accum_angle_i) && $stable(out_relative_angle_i),
    "result changed while stalled")
  `MFMT_ASSERT(a_result_from_frame, $rose(out_valid_i) |->
    $past(in_valid_i && in_ready_i, 2) && ($past(in_action_i, 2) == ActFrame),
    "result without a frame request two cycles before")
  `MFMT_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_i,
    "result shown during reset")

endmodule

bind motor_feedback_multiturn_tracker_core mfmt_checker u_mfmt_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_i.valid),
  .in_ready_i           (in_i.ready),
  .in_action_i          (in_i.action),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_motor_index_i    (out_o.motor_index),
  .out_round_count_i    (out_o.round_count),
  .out_accum_angle_i    (out_o.accum_angle),
  .out_relative_angle_i (out_o.relative_angle)
);
